// File: src/slbc_pkg.sv
// ----------------------------------------------------------------------------
// slbc_pkg
// Shared types and constants for the status LED blink controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slbc_pkg;

   localparam int unsigned MS_W      = 14;
   localparam int unsigned MODE_W    = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = MS_W;

   localparam logic [MS_W-1:0] CNT_MAX = {MS_W{1'b1}};

   // Register reset values
   localparam logic [MS_W-1:0] FLICKER_ON_RST      = MS_W'(10);
   localparam logic [MS_W-1:0] FLICKER_OFF_RST     = MS_W'(90);
   localparam logic [MS_W-1:0] SHORT_PULSE_RST     = MS_W'(500);
   localparam logic [MS_W-1:0] LONG_PULSE_RST      = MS_W'(1000);
   localparam logic [MS_W-1:0] FLICKER_RESTART_RST = MS_W'(10000);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FLICKER_ON      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLICKER_OFF     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PULSE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PULSE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLICKER_RESTART = 3'd4;

   // Request kinds
   localparam logic REQ_MODE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF     = 3'd0,
      MODE_ON      = 3'd1,
      MODE_FLICKER = 3'd2,
      MODE_SHORT   = 3'd3,
      MODE_LONG    = 3'd4,
      MODE_UNKNOWN = 3'd5
   } mode_type;

   typedef struct packed {
      logic [MS_W-1:0] flicker_on_ms;
      logic [MS_W-1:0] flicker_off_ms;
      logic [MS_W-1:0] short_pulse_ms;
      logic [MS_W-1:0] long_pulse_ms;
      logic [MS_W-1:0] flicker_restart_ms;
   } cfg_type;

   typedef struct packed {
      logic              req_type;
      logic [MODE_W-1:0] mode_req;
   } item_type;

   typedef struct packed {
      logic              led_on;
      logic              led_changed;
      logic [MODE_W-1:0] mode_now;
   } result_type;

endpackage

`default_nettype wire

// File: src/slbc_csr.sv
// ----------------------------------------------------------------------------
// slbc_csr
// Timing configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module slbc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [slbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [slbc_pkg::CSR_DAT_W-1:0] csr_wdata,
   output slbc_pkg::cfg_type                   cfg
);
   import slbc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FLICKER_ON:      cfg_in.flicker_on_ms      = csr_wdata;
            CSR_FLICKER_OFF:     cfg_in.flicker_off_ms     = csr_wdata;
            CSR_SHORT_PULSE:     cfg_in.short_pulse_ms     = csr_wdata;
            CSR_LONG_PULSE:      cfg_in.long_pulse_ms      = csr_wdata;
            CSR_FLICKER_RESTART: cfg_in.flicker_restart_ms = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flicker_on_ms      <= FLICKER_ON_RST;
         cfg_ff.flicker_off_ms     <= FLICKER_OFF_RST;
         cfg_ff.short_pulse_ms     <= SHORT_PULSE_RST;
         cfg_ff.long_pulse_ms      <= LONG_PULSE_RST;
         cfg_ff.flicker_restart_ms <= FLICKER_RESTART_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: src/slbc_core.sv
// ----------------------------------------------------------------------------
// slbc_core
// Mode, LED level and millisecond counter; one request evaluated per cycle while advance is high.
// ----------------------------------------------------------------------------
`default_nettype none

module slbc_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  slbc_pkg::item_type        item,
   input  slbc_pkg::cfg_type         cfg,
   output slbc_pkg::result_type      result
);
   import slbc_pkg::*;

   mode_type        mode_ff, mode_in;
   logic            lit_ff, lit_in;
   logic [MS_W-1:0] elapsed_ff, elapsed_in;
   logic [MS_W-1:0] elapsed_inc;
   logic            changed;

   // Saturating increment, used by ticks only
   assign elapsed_inc = (elapsed_ff == CNT_MAX) ? elapsed_ff : elapsed_ff + MS_W'(1);

   always_comb begin
      mode_in    = mode_ff;
      lit_in     = lit_ff;
      elapsed_in = elapsed_ff;
      changed    = 1'b0;
      if (item.req_type == REQ_TICK) begin
         elapsed_in = elapsed_inc;
         if (mode_ff == MODE_FLICKER) begin
            if (lit_ff && (elapsed_inc > cfg.flicker_on_ms)) begin
               lit_in     = 1'b0;
               changed    = 1'b1;
               elapsed_in = '0;
            end else if (!lit_ff && (elapsed_inc > cfg.flicker_off_ms)) begin
               lit_in     = 1'b1;
               changed    = 1'b1;
               elapsed_in = '0;
            end
         end else if (((mode_ff == MODE_SHORT) && (elapsed_inc > cfg.short_pulse_ms)) ||
                      ((mode_ff == MODE_LONG) && (elapsed_inc > cfg.long_pulse_ms))) begin
            lit_in  = 1'b0;
            changed = 1'b1;
            mode_in = MODE_OFF;
         end
      end else begin
         case (item.mode_req)
            MODE_OFF: begin
               if (!(mode_ff inside {MODE_OFF, MODE_SHORT, MODE_LONG})) begin
                  lit_in  = 1'b0;
                  changed = 1'b1;
                  mode_in = MODE_OFF;
               end
            end
            MODE_FLICKER: begin
               if (elapsed_ff > cfg.flicker_restart_ms) begin
                  elapsed_in = '0;
               end
               mode_in = MODE_FLICKER;
            end
            MODE_SHORT, MODE_LONG: begin
               lit_in     = 1'b1;
               changed    = 1'b1;
               elapsed_in = '0;
               mode_in    = mode_type'(item.mode_req);
            end
            default: begin
               // On, and any undefined code, behave as an On request
               if (mode_ff != MODE_ON) begin
                  lit_in  = 1'b1;
                  changed = 1'b1;
                  mode_in = MODE_ON;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_UNKNOWN;
         lit_ff     <= 1'b0;
         elapsed_ff <= '0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         lit_ff     <= lit_in;
         elapsed_ff <= elapsed_in;
      end
   end

   assign result.led_on      = lit_in;
   assign result.led_changed = changed;
   assign result.mode_now    = mode_in;

endmodule

`default_nettype wire

// File: src/status_led_blink_controller.sv
// ----------------------------------------------------------------------------
// status_led_blink_controller
// Red status LED controller: off, on, flicker and two one-shot pulse modes.
// ----------------------------------------------------------------------------
// Each request is either a mode change or a 1 ms tick, and produces exactly
// one response carrying the LED level, whether this request drove the LED,
// and the mode afterwards (5 means no mode has been set since reset). The
// block takes one request per clock cycle unless the response side stalls;
// a request waits in the request register, then its mode update lands in
// the response register together with the new state and the response
// becomes valid. Back-pressure on the response side holds the response
// register and any held request. Timing registers are written through the
// csr_ port and should only change while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_blink_controller (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic                           req_type,
   input  wire logic [slbc_pkg::MODE_W-1:0]    req_mode_req,
   // response channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_led_on,
   output      logic                           rsp_led_changed,
   output      logic [slbc_pkg::MODE_W-1:0]    rsp_mode_now,
   // configuration write port
   input  wire logic                           csr_we,
   input  wire logic [slbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [slbc_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import slbc_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_vld_ff, item_vld_in;
   result_type result;
   result_type rsp_ff;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       advance;

   slbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Advance the held request into the response register when there is room
   assign advance   = item_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !item_vld_ff || advance;

   assign item_in.req_type = req_type;
   assign item_in.mode_req = req_mode_req;

   always_comb begin
      item_vld_in = item_vld_ff;
      if (req_ready) begin
         item_vld_in = req_valid;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         // drop a delivered response
         rsp_vld_in = 1'b0;
      end
   end

   slbc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers: hold unless a new request or result loads them
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_led_on      = rsp_ff.led_on;
   assign rsp_led_changed = rsp_ff.led_changed;
   assign rsp_mode_now    = rsp_ff.mode_now;

endmodule

`default_nettype wire

// File: dv/tb_status_led_blink_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_status_led_blink_controller
// Self-checking regression for the red status LED blink controller.
// ----------------------------------------------------------------------------
// A behavioral copy of the LED mode machine runs beside the block. Every
// request accepted on the req_ channel advances that copy, which queues the
// response the block owes; every response taken on the rsp_ channel is checked
// field by field against the oldest queued one. Timing registers are written
// only while the block is idle. The run starts with directed mode and timing
// checks, runs a burst of back-to-back requests with no stalls, then runs
// random mode and tick traffic under a series of timing settings, zero and
// full scale among them. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_status_led_blink_controller;
   import slbc_pkg::*;

   localparam int     CLK_HALF_NS   = 2;
   localparam int     RESET_CYCLES  = 11;
   localparam int     SETTLE_CYCLES = 4;      // idle wait after the last owed response
   localparam int     IDLE_PCT      = 22;
   localparam int     RANDOM_PHASES = 7;
   localparam int     PHASE_ITEMS   = 112;
   localparam int     BURST_ITEMS   = 120;
   localparam longint LIMIT_NS      = 4_000_000;

   // mode request codes past the defined modes behave as an On request
   localparam logic [MODE_W-1:0]    MODE_SPARE_LAST = 3'd7;
   // register indexes past the last timing register hit nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_FLICKER_RESTART + 1'b1;

   // -------------------------------------------------------------------------
   // DUT connections: every input starts at a known value
   // -------------------------------------------------------------------------
   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   logic                 req_type     = REQ_MODE;
   logic [MODE_W-1:0]    req_mode_req = MODE_OFF;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   logic                 rsp_led_on;
   logic                 rsp_led_changed;
   logic [MODE_W-1:0]    rsp_mode_now;
   logic                 csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_FLICKER_ON;
   logic [CSR_DAT_W-1:0] csr_wdata    = '0;

   // -------------------------------------------------------------------------
   // LED mode machine mirror and response bookkeeping
   // -------------------------------------------------------------------------
   cfg_type         timing_cfg;
   mode_type        led_mode;
   logic            led_lit;
   logic [MS_W-1:0] led_elapsed_ms;

   result_type      led_expect_q[$];

   bit              no_idle;          // suppress gaps and stalls on both sides
   int unsigned     mismatch_count;
   int unsigned     requests_sent;
   int unsigned     ticks_sent;
   int unsigned     responses_checked;
   int unsigned     led_drives_seen;
   int unsigned     timing_settings;

   always #(CLK_HALF_NS) clock = ~clock;

   status_led_blink_controller i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_mode_req    (req_mode_req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_led_on      (rsp_led_on),
      .rsp_led_changed (rsp_led_changed),
      .rsp_mode_now    (rsp_mode_now),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Advance the mirror by one request and return the response it owes
   // -------------------------------------------------------------------------
   function automatic result_type led_advance(input item_type it);
      result_type res;
      logic       drove;
      drove = 1'b0;
      if (it.req_type == REQ_TICK) begin
         // count first, saturating, then let the mode look at the new count
         if (led_elapsed_ms != CNT_MAX) led_elapsed_ms = led_elapsed_ms + 1'b1;
         if (led_mode == MODE_FLICKER) begin
            if (led_lit && led_elapsed_ms > timing_cfg.flicker_on_ms) begin
               led_lit        = 1'b0;
               drove          = 1'b1;
               led_elapsed_ms = '0;
            end else if (!led_lit && led_elapsed_ms > timing_cfg.flicker_off_ms) begin
               led_lit        = 1'b1;
               drove          = 1'b1;
               led_elapsed_ms = '0;
            end
         end else if ((led_mode == MODE_SHORT && led_elapsed_ms > timing_cfg.short_pulse_ms) ||
                      (led_mode == MODE_LONG  && led_elapsed_ms > timing_cfg.long_pulse_ms)) begin
            // one-shot expired: darken and fall back to Off
            led_lit  = 1'b0;
            drove    = 1'b1;
            led_mode = MODE_OFF;
         end
      end else begin
         case (it.mode_req)
            MODE_OFF: begin
               // Off is dropped while already off or inside a one-shot
               if (led_mode != MODE_OFF && led_mode != MODE_SHORT && led_mode != MODE_LONG) begin
                  led_lit  = 1'b0;
                  drove    = 1'b1;
                  led_mode = MODE_OFF;
               end
            end
            MODE_FLICKER: begin
               if (led_elapsed_ms > timing_cfg.flicker_restart_ms) led_elapsed_ms = '0;
               led_mode = MODE_FLICKER;
            end
            MODE_SHORT, MODE_LONG: begin
               led_lit        = 1'b1;
               drove          = 1'b1;
               led_elapsed_ms = '0;
               led_mode       = mode_type'(it.mode_req);
            end
            default: begin
               // On, and every undefined code, lights the LED unless already On
               if (led_mode != MODE_ON) begin
                  led_lit  = 1'b1;
                  drove    = 1'b1;
                  led_mode = MODE_ON;
               end
            end
         endcase
      end
      res.led_on      = led_lit;
      res.led_changed = drove;
      res.mode_now    = led_mode;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got_v,
                                  input int unsigned want_v);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
      mismatch_count++;
   endtask

   // -------------------------------------------------------------------------
   // Monitor: sample both channels and the register port at each rising edge.
   // Check responses before queueing the request taken at the same edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got;
      result_type want;
      item_type   it;
      if (reset) begin
         timing_cfg.flicker_on_ms      = FLICKER_ON_RST;
         timing_cfg.flicker_off_ms     = FLICKER_OFF_RST;
         timing_cfg.short_pulse_ms     = SHORT_PULSE_RST;
         timing_cfg.long_pulse_ms      = LONG_PULSE_RST;
         timing_cfg.flicker_restart_ms = FLICKER_RESTART_RST;
         led_mode       = MODE_UNKNOWN;
         led_lit        = 1'b0;
         led_elapsed_ms = '0;
         led_expect_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FLICKER_ON:      timing_cfg.flicker_on_ms      = csr_wdata;
               CSR_FLICKER_OFF:     timing_cfg.flicker_off_ms     = csr_wdata;
               CSR_SHORT_PULSE:     timing_cfg.short_pulse_ms     = csr_wdata;
               CSR_LONG_PULSE:      timing_cfg.long_pulse_ms      = csr_wdata;
               CSR_FLICKER_RESTART: timing_cfg.flicker_restart_ms = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.led_on      = rsp_led_on;
            got.led_changed = rsp_led_changed;
            got.mode_now    = rsp_mode_now;
            if (led_expect_q.size() == 0) begin
               report_mismatch("unexpected response, mode_now", 32'(got.mode_now), 0);
            end else begin
               want = led_expect_q.pop_front();
               if (got.led_on !== want.led_on)
                  report_mismatch("led_on", 32'(got.led_on), 32'(want.led_on));
               if (got.led_changed !== want.led_changed)
                  report_mismatch("led_changed", 32'(got.led_changed),
                                  32'(want.led_changed));
               if (got.mode_now !== want.mode_now)
                  report_mismatch("mode_now", 32'(got.mode_now), 32'(want.mode_now));
               if (want.led_changed) led_drives_seen++;
               responses_checked++;
            end
         end
         if (req_valid && req_ready) begin
            it.req_type = req_type;
            it.mode_req = req_mode_req;
            led_expect_q.push_back(led_advance(it));
            requests_sent++;
            if (req_type == REQ_TICK) ticks_sent++;
         end
      end
   end

   // Stall the response side in about a fifth of the cycles
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers; every call starts and ends right after a rising edge
   // -------------------------------------------------------------------------
   task automatic send_request(input logic kind, input logic [MODE_W-1:0] mode);
      // insert random gaps, then hold valid and payload until taken
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_mode_req <= mode;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_ticks(input int count);
      // mode_req rides along at random; the block must ignore it on a tick
      repeat (count) send_request(REQ_TICK, MODE_W'($urandom_range(MODE_SPARE_LAST)));
   endtask

   // Drop valid, wait for every owed response, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (led_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all five timing registers back to back, then poke a spare index
   task automatic set_timing(input logic [MS_W-1:0] on_ms, input logic [MS_W-1:0] off_ms,
                             input logic [MS_W-1:0] short_ms, input logic [MS_W-1:0] long_ms,
                             input logic [MS_W-1:0] restart_ms);
      csr_we    <= 1'b1;
      csr_index <= CSR_FLICKER_ON;
      csr_wdata <= on_ms;
      @(posedge clock);
      csr_index <= CSR_FLICKER_OFF;
      csr_wdata <= off_ms;
      @(posedge clock);
      csr_index <= CSR_SHORT_PULSE;
      csr_wdata <= short_ms;
      @(posedge clock);
      csr_index <= CSR_LONG_PULSE;
      csr_wdata <= long_ms;
      @(posedge clock);
      csr_index <= CSR_FLICKER_RESTART;
      csr_wdata <= restart_ms;
      @(posedge clock);
      csr_index <= CSR_SPARE_FIRST + CSR_IDX_W'($urandom_range(2));
      csr_wdata <= CSR_DAT_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      timing_settings++;
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Walk every mode request from the unknown state at reset timing
   task automatic test_mode_requests();
      int code;
      send_ticks(1);                        // unknown mode: tick leaves LED alone
      send_request(REQ_MODE, MODE_OFF);     // unknown is not off: drive dark
      send_request(REQ_MODE, MODE_OFF);     // redundant off
      send_request(REQ_MODE, MODE_ON);
      send_request(REQ_MODE, MODE_ON);      // redundant on
      send_request(REQ_MODE, MODE_OFF);
      for (code = MODE_UNKNOWN; code <= MODE_SPARE_LAST; code++) begin
         send_request(REQ_MODE, MODE_W'(code));   // undefined code acts as On
         send_request(REQ_MODE, MODE_OFF);
      end
      send_request(REQ_MODE, MODE_ON);
      send_request(REQ_MODE, MODE_FLICKER); // no LED drive on entry
      send_ticks(2);
      send_request(REQ_MODE, MODE_SHORT);
      send_request(REQ_MODE, MODE_OFF);     // dropped inside a one-shot
      send_request(REQ_MODE, MODE_LONG);
      send_request(REQ_MODE, MODE_OFF);     // dropped inside a one-shot
      send_request(REQ_MODE, MODE_FLICKER);
      send_request(REQ_MODE, MODE_OFF);     // flicker to off drives dark
   endtask

   // Short timing so flicker edges, pulse expiry and restart all show up
   task automatic test_short_timing();
      settle();
      set_timing(MS_W'(2), MS_W'(3), MS_W'(1), MS_W'(4), '0);
      send_request(REQ_MODE, MODE_ON);
      send_request(REQ_MODE, MODE_FLICKER);
      send_ticks(8);
      send_request(REQ_MODE, MODE_SHORT);
      send_ticks(2);                        // expires on the second tick
      send_request(REQ_MODE, MODE_LONG);
      send_ticks(5);
      send_request(REQ_MODE, MODE_FLICKER);
      send_ticks(1);
      send_request(REQ_MODE, MODE_FLICKER); // elapsed above zero: restart
      send_ticks(1);
   endtask

   // Back-to-back requests with the response side never stalled
   task automatic test_back_to_back();
      int n;
      settle();
      set_timing(MS_W'(3), MS_W'(5), MS_W'(6), MS_W'(9), MS_W'(4));
      no_idle = 1'b1;
      for (n = 0; n < BURST_ITEMS; n++) begin
         // a mode request every fourth slot, ticks in between
         if (n % 4 == 0)
            send_request(REQ_MODE, MODE_W'($urandom_range(MODE_SPARE_LAST)));
         else
            send_ticks(1);
      end
      settle();
      no_idle = 1'b0;
   endtask

   // Random mode requests, each followed by a run of ticks, per timing setting
   task automatic test_random_traffic();
      int          phase;
      int          sent;
      int          run;
      logic [MS_W-1:0] on_ms, off_ms, short_ms, long_ms, restart_ms;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case (phase)
            0: begin
               on_ms = '0; off_ms = '0; short_ms = '0; long_ms = '0; restart_ms = '0;
            end
            1: begin
               on_ms = CNT_MAX; off_ms = CNT_MAX; short_ms = CNT_MAX;
               long_ms = CNT_MAX; restart_ms = CNT_MAX;
            end
            2: begin
               on_ms = FLICKER_ON_RST; off_ms = FLICKER_OFF_RST; short_ms = SHORT_PULSE_RST;
               long_ms = LONG_PULSE_RST; restart_ms = FLICKER_RESTART_RST;
            end
            default: begin
               on_ms      = MS_W'($urandom_range(8));
               off_ms     = MS_W'($urandom_range(12));
               short_ms   = MS_W'($urandom_range(20));
               long_ms    = MS_W'($urandom_range(30));
               restart_ms = MS_W'($urandom_range(40));
            end
         endcase
         set_timing(on_ms, off_ms, short_ms, long_ms, restart_ms);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // mostly defined modes, now and then an undefined code
            if ($urandom_range(99) < 85)
               send_request(REQ_MODE, MODE_W'($urandom_range(MODE_LONG)));
            else
               send_request(REQ_MODE, MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_UNKNOWN)));
            run = $urandom_range(25);
            send_ticks(run);
            sent += run + 1;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence the run
   // -------------------------------------------------------------------------
   initial begin
      no_idle = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_mode_requests();
      test_short_timing();
      test_back_to_back();
      test_random_traffic();
      settle();
      $display("covered %0d requests (%0d ticks) across %0d timing settings,",
               requests_sent, ticks_sent, timing_settings);
      $display("checked %0d responses, %0d of which drove the LED",
               responses_checked, led_drives_seen);
      if (mismatch_count == 0) begin
         $display("status_led_blink_controller regression: pass");
      end else begin
         $display("status_led_blink_controller regression: fail");
      end
      $finish;
   end

   // Hard stop if a handshake hangs
   initial begin
      #(LIMIT_NS);
      $display("status_led_blink_controller regression: fail");
      $finish;
   end

endmodule

// File: files.f
src/slbc_pkg.sv
src/slbc_csr.sv
src/slbc_core.sv
src/status_led_blink_controller.sv
dv/tb_status_led_blink_controller.sv
